// ===== rtl/rlbsd_pkg.sv =====
// Shared constants and types of the run-length bitmap span decoder.
package rlbsd_pkg;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 16;
    localparam int MODE_W    = 2;
    localparam int PAYLOAD_W = 14;
    localparam int LEN_W     = 12;
    localparam int BIT_W     = 4;
    localparam int MAX_SEGS  = 33;
    localparam int CNT_W     = 6;

    localparam logic [CFG_W-1:0] MIN_WIDTH = 12'd512;
    localparam logic [CFG_W-1:0] WIDTH_RST = 12'd800;
    localparam logic [CFG_W-1:0] COUNT_RST = 12'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LIT,
        MODE_WHITE,
        MODE_BLACK,
        MODE_NONE
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_LIT,
        ST_BLK,
        ST_ADV,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/rlbsd_adv_unit.sv =====
// Cursor advance unit: adds an amount, folds one line width, steps and clamps the row.
module rlbsd_adv_unit #(
    parameter int COORD_WIDTH = 12,
    parameter int COL_W       = 15
) (
    input  logic [COL_W-1:0]                 i_base,
    input  logic [rlbsd_pkg::PAYLOAD_W-1:0]  i_addend,
    input  logic [COORD_WIDTH-1:0]           i_row,
    input  logic [rlbsd_pkg::CFG_W-1:0]      i_width,
    input  logic [rlbsd_pkg::CFG_W-1:0]      i_count,
    output logic [COL_W-1:0]                 o_col,
    output logic [COORD_WIDTH-1:0]           o_row,
    output logic                             o_done
);

    localparam int RW = ((COORD_WIDTH > rlbsd_pkg::CFG_W) ? COORD_WIDTH : rlbsd_pkg::CFG_W) + 1;

    logic [COL_W-1:0] sum;
    logic [COL_W-1:0] width_ext;
    logic             ge;
    logic [RW-1:0]    row_step;
    logic [RW-1:0]    count_ext;

    assign width_ext = COL_W'(i_width);
    assign sum       = i_base + COL_W'(i_addend);
    assign ge        = (sum >= width_ext);
    assign o_col     = ge ? (sum - width_ext) : sum;
    assign row_step  = RW'(i_row) + RW'(ge);
    assign count_ext = RW'(i_count);
    assign o_row     = (row_step > count_ext) ? COORD_WIDTH'(count_ext)
                                              : COORD_WIDTH'(row_step);
    assign o_done    = !ge;

endmodule

// ===== rtl/run_length_bitmap_span_decoder_unit.sv =====
// Top level of the run-length bitmap span decoder.
//
//  channel  direction  handshake                     payload
//  in       sink       i_in_valid / o_in_stall       i_frame_start, i_code_word
//  out      source     o_out_valid / i_out_stall     o_clear_screen, o_seg_row, o_seg_column,
//                                                    o_seg_length, o_last
//  cfg      sink       i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One word at a time; o_in_stall is high until its last beat, if any, is in the output register.
// Frame start: a clear beat. Ignored mode: straight to the finish step.
// Literal: one bit step per payload bit, plus an advance step per row wrap. White run: the
// shared advance unit subtracts one line width per cycle while the sequencer is not held.
// A new beat meeting a full, stalled output register holds the sequencer.
// Synchronous reset; no clearing pass.
module run_length_bitmap_span_decoder_unit #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_frame_start,
    input  logic [rlbsd_pkg::WORD_W-1:0]       i_code_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_clear_screen,
    output logic [COORD_WIDTH-1:0]             o_seg_row,
    output logic [COORD_WIDTH-1:0]             o_seg_column,
    output logic [rlbsd_pkg::LEN_W-1:0]        o_seg_length,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rlbsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlbsd_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int COL_W = ((COORD_WIDTH > rlbsd_pkg::PAYLOAD_W) ? COORD_WIDTH
                                                                 : rlbsd_pkg::PAYLOAD_W) + 1;
    localparam int RW    = ((COORD_WIDTH > rlbsd_pkg::CFG_W) ? COORD_WIDTH
                                                             : rlbsd_pkg::CFG_W) + 1;

    rlbsd_pkg::t_state r_state, n_state;
    rlbsd_pkg::t_state r_ret, n_ret;

    logic [COL_W-1:0]                  r_col, n_col;
    logic [COORD_WIDTH-1:0]            r_row, n_row;
    logic [rlbsd_pkg::CFG_W-1:0]       r_weff;
    logic [rlbsd_pkg::CFG_W-1:0]       r_lc;
    logic [rlbsd_pkg::PAYLOAD_W-1:0]   r_pay, n_pay;
    logic [rlbsd_pkg::PAYLOAD_W-1:0]   r_left, n_left;
    logic [rlbsd_pkg::PAYLOAD_W-1:0]   r_amt, n_amt;
    logic [rlbsd_pkg::BIT_W-1:0]       r_bit, n_bit;
    logic                              r_pv, n_pv;
    logic [COORD_WIDTH-1:0]            r_prow, n_prow;
    logic [COORD_WIDTH-1:0]            r_pcol, n_pcol;
    logic [rlbsd_pkg::LEN_W-1:0]       r_plen, n_plen;
    logic [rlbsd_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    logic                              r_ov;
    logic                              r_oclr;
    logic [COORD_WIDTH-1:0]            r_orow;
    logic [COORD_WIDTH-1:0]            r_ocol;
    logic [rlbsd_pkg::LEN_W-1:0]       r_olen;
    logic                              r_olast;

    logic                              e_valid;
    logic                              e_clr;
    logic [COORD_WIDTH-1:0]            e_row;
    logic [COORD_WIDTH-1:0]            e_col;
    logic [rlbsd_pkg::LEN_W-1:0]       e_len;
    logic                              e_last;

    logic [rlbsd_pkg::PAYLOAD_W-1:0]   u_add;
    logic [COL_W-1:0]                  u_col;
    logic [COORD_WIDTH-1:0]            u_row;
    logic                              u_done;

    logic                              in_acc;
    logic                              out_free;
    logic                              step;
    logic                              row_vis;
    logic                              col_vis;
    logic                              merge;
    logic                              room;
    logic                              cur_bit;
    logic [rlbsd_pkg::CFG_W-1:0]       rem;
    logic [rlbsd_pkg::PAYLOAD_W-1:0]   take;
    rlbsd_pkg::t_state                 lit_ret;

    rlbsd_adv_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .COL_W       (COL_W)
    ) u_adv (
        .i_base   (r_col),
        .i_addend (u_add),
        .i_row    (r_row),
        .i_width  (r_weff),
        .i_count  (r_lc),
        .o_col    (u_col),
        .o_row    (u_row),
        .o_done   (u_done)
    );

    assign o_in_stall  = (r_state != rlbsd_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == rlbsd_pkg::ST_IDLE);
    assign out_free    = !r_ov || !i_out_stall;
    assign step        = !e_valid || out_free;
    assign o_cfg_ready = 1'b1;

    assign row_vis = (RW'(r_row) < RW'(r_lc));
    assign col_vis = (r_col < COL_W'(r_weff));
    assign merge   = r_pv && (r_prow == r_row)
                     && ((COL_W'(r_pcol) + COL_W'(r_plen)) == r_col);
    assign room    = (r_cnt < rlbsd_pkg::CNT_W'(rlbsd_pkg::MAX_SEGS));
    assign cur_bit = r_pay[r_bit];
    assign rem     = r_weff - rlbsd_pkg::CFG_W'(r_col);
    assign take    = (r_left < rlbsd_pkg::PAYLOAD_W'(rem)) ? r_left
                                                           : rlbsd_pkg::PAYLOAD_W'(rem);
    assign lit_ret = (r_bit == '0) ? rlbsd_pkg::ST_FIN : rlbsd_pkg::ST_LIT;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_col   = r_col;
        n_row   = r_row;
        n_pay   = r_pay;
        n_left  = r_left;
        n_amt   = r_amt;
        n_bit   = r_bit;
        n_pv    = r_pv;
        n_prow  = r_prow;
        n_pcol  = r_pcol;
        n_plen  = r_plen;
        n_cnt   = r_cnt;
        e_valid = 1'b0;
        e_clr   = 1'b0;
        e_row   = r_prow;
        e_col   = r_pcol;
        e_len   = r_plen;
        e_last  = 1'b0;
        u_add   = '0;
        unique case (r_state)
            rlbsd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_frame_start) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_state = rlbsd_pkg::ST_CLR;
                    end else begin
                        n_pay = i_code_word[rlbsd_pkg::PAYLOAD_W-1:0];
                        n_pv  = 1'b0;
                        n_cnt = '0;
                        unique case (rlbsd_pkg::t_mode'(
                                i_code_word[rlbsd_pkg::WORD_W-1 -: rlbsd_pkg::MODE_W]))
                            rlbsd_pkg::MODE_LIT: begin
                                n_bit   = rlbsd_pkg::BIT_W'(rlbsd_pkg::PAYLOAD_W - 1);
                                n_state = rlbsd_pkg::ST_LIT;
                            end
                            rlbsd_pkg::MODE_WHITE: begin
                                n_amt   = i_code_word[rlbsd_pkg::PAYLOAD_W-1:0];
                                n_ret   = rlbsd_pkg::ST_FIN;
                                n_state = rlbsd_pkg::ST_ADV;
                            end
                            rlbsd_pkg::MODE_BLACK: begin
                                n_left  = i_code_word[rlbsd_pkg::PAYLOAD_W-1:0];
                                n_state = rlbsd_pkg::ST_BLK;
                            end
                            default: begin
                                n_state = rlbsd_pkg::ST_FIN;
                            end
                        endcase
                    end
                end
            end
            rlbsd_pkg::ST_CLR: begin
                e_valid = 1'b1;
                e_clr   = 1'b1;
                e_last  = 1'b1;
                e_row   = '0;
                e_col   = '0;
                e_len   = '0;
                n_state = rlbsd_pkg::ST_IDLE;
            end
            rlbsd_pkg::ST_LIT: begin
                u_add = rlbsd_pkg::PAYLOAD_W'(1);
                if (cur_bit && row_vis && col_vis) begin
                    if (merge) begin
                        n_plen = r_plen + rlbsd_pkg::LEN_W'(1);
                    end else if (room) begin
                        e_valid = r_pv;
                        n_pv    = 1'b1;
                        n_prow  = r_row;
                        n_pcol  = COORD_WIDTH'(r_col);
                        n_plen  = rlbsd_pkg::LEN_W'(1);
                        n_cnt   = r_cnt + rlbsd_pkg::CNT_W'(1);
                    end
                end
                n_col   = u_col;
                n_row   = u_row;
                n_bit   = r_bit - rlbsd_pkg::BIT_W'(1);
                n_ret   = lit_ret;
                n_amt   = '0;
                n_state = u_done ? lit_ret : rlbsd_pkg::ST_ADV;
            end
            rlbsd_pkg::ST_BLK: begin
                n_ret = rlbsd_pkg::ST_BLK;
                if (r_left == '0) begin
                    n_state = rlbsd_pkg::ST_FIN;
                end else if (!row_vis) begin
                    n_amt   = r_left;
                    n_left  = '0;
                    n_state = rlbsd_pkg::ST_ADV;
                end else if (!col_vis) begin
                    n_amt   = rlbsd_pkg::PAYLOAD_W'(1);
                    n_left  = r_left - rlbsd_pkg::PAYLOAD_W'(1);
                    n_state = rlbsd_pkg::ST_ADV;
                end else begin
                    if (room) begin
                        e_valid = r_pv;
                        n_pv    = 1'b1;
                        n_prow  = r_row;
                        n_pcol  = COORD_WIDTH'(r_col);
                        n_plen  = rlbsd_pkg::LEN_W'(take);
                        n_cnt   = r_cnt + rlbsd_pkg::CNT_W'(1);
                    end
                    n_amt   = take;
                    n_left  = r_left - take;
                    n_state = rlbsd_pkg::ST_ADV;
                end
            end
            rlbsd_pkg::ST_ADV: begin
                u_add   = r_amt;
                n_col   = u_col;
                n_row   = u_row;
                n_amt   = '0;
                n_state = u_done ? r_ret : rlbsd_pkg::ST_ADV;
            end
            rlbsd_pkg::ST_FIN: begin
                e_valid = r_pv;
                e_last  = 1'b1;
                n_pv    = 1'b0;
                n_state = rlbsd_pkg::ST_IDLE;
            end
            default: begin
                n_state = rlbsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlbsd_pkg::ST_IDLE;
            r_ret   <= rlbsd_pkg::ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_pv    <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_weff  <= rlbsd_pkg::WIDTH_RST;
            r_lc    <= rlbsd_pkg::COUNT_RST;
        end else begin
            if (step) begin
                r_state <= n_state;
                r_ret   <= n_ret;
                r_col   <= n_col;
                r_row   <= n_row;
                r_pv    <= n_pv;
                r_cnt   <= n_cnt;
            end
            if (e_valid && step) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rlbsd_pkg::CFG_LINE_WIDTH: begin
                        r_weff <= (i_cfg_data < rlbsd_pkg::MIN_WIDTH) ? rlbsd_pkg::MIN_WIDTH
                                                                      : i_cfg_data;
                    end
                    rlbsd_pkg::CFG_LINE_COUNT: begin
                        r_lc <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_pay  <= n_pay;
            r_left <= n_left;
            r_amt  <= n_amt;
            r_bit  <= n_bit;
            r_prow <= n_prow;
            r_pcol <= n_pcol;
            r_plen <= n_plen;
        end
        if (e_valid && step) begin
            r_oclr  <= e_clr;
            r_orow  <= e_row;
            r_ocol  <= e_col;
            r_olen  <= e_len;
            r_olast <= e_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_clear_screen = r_oclr;
    assign o_seg_row      = r_orow;
    assign o_seg_column   = r_ocol;
    assign o_seg_length   = r_olen;
    assign o_last         = r_olast;

    a_clr_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlbsd_pkg::ST_CLR) |-> (r_col == '0 && r_row == '0))
        else $error("cursor not homed during clear beat");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlbsd_pkg::ST_IDLE) |-> !r_pv)
        else $error("pending segment left over in idle");

    a_pend_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_plen != '0))
        else $error("pending segment of zero length");

    a_clr_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oclr) |-> (r_olast && r_olen == '0))
        else $error("clear beat malformed");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlbsd_pkg::ST_FIN && r_pv && step) |=> (r_ov && r_olast && !r_oclr))
        else $error("final segment not delivered with last");

endmodule

// ===== sim/run_length_bitmap_span_decoder_unit_test.sv =====
// Self-checking testbench of the run-length bitmap span decoder unit.
module run_length_bitmap_span_decoder_unit_test;

    localparam int COORD_W        = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_WORDS   = 22;

    localparam logic [rlbsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [rlbsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        bit          clr;
        int unsigned row;
        int unsigned col;
        int unsigned len;
        bit          last;
    } t_span;

    class t_span_scoreboard;
        int unsigned line_width;
        int unsigned line_count;
        int unsigned cur_col;
        int unsigned cur_row;
        t_span       word_spans[$];
        t_span       expected_spans[$];
        int          fails;

        function new();
            line_width = rlbsd_pkg::WIDTH_RST;
            line_count = rlbsd_pkg::COUNT_RST;
            cur_col    = 0;
            cur_row    = 0;
            fails      = 0;
        endfunction

        function void write_reg(logic [rlbsd_pkg::CFG_IDX_W-1:0] idx,
                                logic [rlbsd_pkg::CFG_W-1:0] data);
            if (idx == rlbsd_pkg::CFG_LINE_WIDTH) begin
                line_width = data;
            end else if (idx == rlbsd_pkg::CFG_LINE_COUNT) begin
                line_count = data;
            end
        endfunction

        function int unsigned eff_width();
            return (line_width < rlbsd_pkg::MIN_WIDTH) ? rlbsd_pkg::MIN_WIDTH : line_width;
        endfunction

        function void advance(int unsigned amount);
            int unsigned w, c, r;
            w = eff_width();
            c = cur_col + amount;
            r = cur_row + c / w;
            c = c % w;
            if (r > line_count) begin
                r = line_count;
            end
            cur_col = c & ((1 << COORD_W) - 1);
            cur_row = r & ((1 << COORD_W) - 1);
        endfunction

        function void draw_pixel();
            int n;
            n = word_spans.size();
            if (cur_row >= line_count || cur_col >= eff_width()) begin
                return;
            end
            if (n > 0 && word_spans[n-1].row == cur_row &&
                word_spans[n-1].col + word_spans[n-1].len == cur_col) begin
                word_spans[n-1].len = word_spans[n-1].len + 1;
                return;
            end
            if (n >= rlbsd_pkg::MAX_SEGS) begin
                return;
            end
            word_spans.insert(n, t_span'{1'b0, cur_row, cur_col, 1, 1'b0});
        endfunction

        // Accepted input beat: predict the segments it produces.
        function void note_word(bit fs, logic [rlbsd_pkg::WORD_W-1:0] word);
            logic [rlbsd_pkg::PAYLOAD_W-1:0] payload;
            payload = word[rlbsd_pkg::PAYLOAD_W-1:0];
            if (fs) begin
                cur_col = 0;
                cur_row = 0;
                expected_spans.insert(expected_spans.size(), t_span'{1'b1, 0, 0, 0, 1'b1});
                return;
            end
            word_spans.delete();
            case (rlbsd_pkg::t_mode'(word[rlbsd_pkg::WORD_W-1 -: rlbsd_pkg::MODE_W]))
                rlbsd_pkg::MODE_LIT: begin
                    for (int k = rlbsd_pkg::PAYLOAD_W - 1; k >= 0; k--) begin
                        if (payload[k]) begin
                            draw_pixel();
                        end
                        advance(1);
                    end
                end
                rlbsd_pkg::MODE_WHITE: begin
                    advance(payload);
                end
                rlbsd_pkg::MODE_BLACK: begin
                    for (int n = payload; n > 0; n--) begin
                        draw_pixel();
                        advance(1);
                    end
                end
                default: begin
                end
            endcase
            foreach (word_spans[k]) begin
                word_spans[k].last = (k == word_spans.size() - 1);
                expected_spans.insert(expected_spans.size(), word_spans[k]);
            end
        endfunction

        function void compare_field(string name, int unsigned expv, logic [15:0] act);
            if (act !== 16'(expv)) begin
                $error("%s: expected %0d, actual %0d", name, expv, act);
                fails++;
            end
        endfunction

        // Accepted output beat: compare with the oldest prediction.
        function void check_beat(logic clr, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                 logic [rlbsd_pkg::LEN_W-1:0] len, logic last);
            t_span exp_span;
            if (expected_spans.size() == 0) begin
                $error("unexpected beat: row %0d column %0d length %0d", row, col, len);
                fails++;
                return;
            end
            exp_span = expected_spans.pop_front();
            compare_field("clear_screen", 32'(exp_span.clr), 16'(clr));
            compare_field("seg_row", exp_span.row, 16'(row));
            compare_field("seg_column", exp_span.col, 16'(col));
            compare_field("seg_length", exp_span.len, 16'(len));
            compare_field("last", 32'(exp_span.last), 16'(last));
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction
    endclass

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_in_valid    = 1'b0;
    logic                                i_frame_start = 1'b0;
    logic [rlbsd_pkg::WORD_W-1:0]        i_code_word   = '0;
    logic                                i_out_stall   = 1'b0;
    logic                                i_cfg_valid   = 1'b0;
    logic [rlbsd_pkg::CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [rlbsd_pkg::CFG_W-1:0]         i_cfg_data    = '0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic                                o_clear_screen;
    logic [COORD_W-1:0]                  o_seg_row;
    logic [COORD_W-1:0]                  o_seg_column;
    logic [rlbsd_pkg::LEN_W-1:0]         o_seg_length;
    logic                                o_last;
    logic                                o_cfg_ready;

    t_span_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_phase = 0;
    int burst_left  = 1;
    bit in_valid_up = 1'b0;

    run_length_bitmap_span_decoder_unit #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_start  (i_frame_start),
        .i_code_word    (i_code_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_clear_screen (o_clear_screen),
        .o_seg_row      (o_seg_row),
        .o_seg_column   (o_seg_column),
        .o_seg_length   (o_seg_length),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Receiver stall pattern: free, random, periodic, long runs.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            case (stall_phase[8:7])
                2'd0:    i_out_stall <= 1'b0;
                2'd1:    i_out_stall <= ($urandom_range(0, 1) == 1);
                2'd2:    i_out_stall <= (stall_phase % 5 < 2);
                default: i_out_stall <= (stall_phase[3:0] > 4'd5);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_beat(o_clear_screen, o_seg_row, o_seg_column, o_seg_length, o_last);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** run_length_bitmap_span_decoder_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [rlbsd_pkg::WORD_W-1:0] code(rlbsd_pkg::t_mode m,
                                                          int unsigned payload);
        return {m, rlbsd_pkg::PAYLOAD_W'(payload)};
    endfunction

    task automatic lower_in_valid();
        if (in_valid_up) begin
            i_in_valid  <= 1'b0;
            in_valid_up = 1'b0;
        end
    endtask

    task automatic drive_word(bit fs, logic [rlbsd_pkg::WORD_W-1:0] word);
        i_in_valid    <= 1'b1;
        in_valid_up   = 1'b1;
        i_frame_start <= fs;
        i_code_word   <= word;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_word(fs, word);
        burst_left--;
        if (burst_left <= 0) begin
            lower_in_valid();
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic wait_quiet();
        lower_in_valid();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rlbsd_pkg::CFG_IDX_W-1:0] idx,
                             logic [rlbsd_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    task automatic set_geometry(int unsigned width, int unsigned count);
        wait_quiet();
        write_reg(rlbsd_pkg::CFG_LINE_WIDTH, rlbsd_pkg::CFG_W'(width));
        write_reg(CFG_SPARE_LO, rlbsd_pkg::CFG_W'($urandom));
        write_reg(CFG_SPARE_HI, rlbsd_pkg::CFG_W'($urandom));
        write_reg(rlbsd_pkg::CFG_LINE_COUNT, rlbsd_pkg::CFG_W'(count));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_words(int n);
        int unsigned                  pick;
        logic [rlbsd_pkg::WORD_W-1:0] word;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            word = rlbsd_pkg::WORD_W'($urandom);
            if (pick < 7) begin
                drive_word(1'b1, word);
            end else begin
                if (pick < 45) begin
                    word[rlbsd_pkg::WORD_W-1 -: rlbsd_pkg::MODE_W] = rlbsd_pkg::MODE_LIT;
                end else if (pick < 62) begin
                    word[rlbsd_pkg::WORD_W-1 -: rlbsd_pkg::MODE_W] = rlbsd_pkg::MODE_WHITE;
                    if ($urandom_range(0, 7) != 0) begin
                        word[rlbsd_pkg::PAYLOAD_W-1:0] =
                            rlbsd_pkg::PAYLOAD_W'($urandom_range(0, 1500));
                    end
                end else if (pick < 92) begin
                    word[rlbsd_pkg::WORD_W-1 -: rlbsd_pkg::MODE_W] = rlbsd_pkg::MODE_BLACK;
                    if ($urandom_range(0, 9) != 0) begin
                        word[rlbsd_pkg::PAYLOAD_W-1:0] =
                            rlbsd_pkg::PAYLOAD_W'($urandom_range(0, 1200));
                    end
                end else begin
                    word[rlbsd_pkg::WORD_W-1 -: rlbsd_pkg::MODE_W] = rlbsd_pkg::MODE_NONE;
                end
                drive_word(1'b0, word);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry 800 x 480
        drive_word(1'b1, 16'hFFFF);
        drive_word(1'b0, code(rlbsd_pkg::MODE_LIT, 14'h3FFF));
        drive_word(1'b0, code(rlbsd_pkg::MODE_LIT, 14'h2AAA));
        drive_word(1'b0, code(rlbsd_pkg::MODE_LIT, 14'h1555));
        drive_word(1'b0, code(rlbsd_pkg::MODE_LIT, 0));
        drive_word(1'b0, code(rlbsd_pkg::MODE_WHITE, 0));
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 0));
        drive_word(1'b0, code(rlbsd_pkg::MODE_NONE, 0));
        drive_word(1'b0, code(rlbsd_pkg::MODE_NONE, 14'h3FFF));
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 14'h3FFF));
        drive_word(1'b1, 16'h0000);
        drive_word(1'b0, code(rlbsd_pkg::MODE_WHITE, 790));
        drive_word(1'b0, code(rlbsd_pkg::MODE_LIT, 14'h3FFF));
        drive_word(1'b0, code(rlbsd_pkg::MODE_WHITE, 14'h3FFF));
        random_words(RANDOM_WORDS);

        // narrowest width, most segments per word
        set_geometry(512, 4095);
        drive_word(1'b1, 16'h0000);
        drive_word(1'b0, code(rlbsd_pkg::MODE_WHITE, 100));
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 14'h3FFF));
        random_words(RANDOM_WORDS);

        // one row: everything past it is clamped
        set_geometry(4095, 1);
        drive_word(1'b1, 16'h0000);
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 5000));
        drive_word(1'b0, code(rlbsd_pkg::MODE_LIT, 14'h3FFF));
        drive_word(1'b0, code(rlbsd_pkg::MODE_WHITE, 0));
        random_words(RANDOM_WORDS);

        // width below minimum acts as 512
        set_geometry(100, 2);
        drive_word(1'b1, 16'h0000);
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 600));
        random_words(RANDOM_WORDS);

        set_geometry(0, 0);
        drive_word(1'b1, 16'h0000);
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 600));
        random_words(RANDOM_WORDS);

        // cursor left beyond a lowered width
        set_geometry(4095, 4095);
        drive_word(1'b1, 16'h0000);
        drive_word(1'b0, code(rlbsd_pkg::MODE_WHITE, 3000));
        set_geometry(600, 480);
        drive_word(1'b0, code(rlbsd_pkg::MODE_BLACK, 5));
        random_words(RANDOM_WORDS);

        set_geometry($urandom_range(512, 4095), $urandom_range(1, 4095));
        random_words(RANDOM_WORDS);

        wait_quiet();
        if (sb.fails == 0) begin
            $display("** run_length_bitmap_span_decoder_unit: PASSED **");
        end else begin
            $display("** run_length_bitmap_span_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
